### hw/rtl/rfcp_pkg.sv
// Package for the radio frame checker and parser: frame constants, result
// status codes, the CRC-16 (reflected 0x8408) byte update and shared types.
// No dependencies.
package rfcp_pkg;

   localparam logic [7:0]  LEN_MASK      = 8'h1F;
   localparam logic [5:0]  HEADER_BYTES  = 6'd1;
   localparam logic [5:0]  TRAILER_BYTES = 6'd2;
   localparam logic [5:0]  MIN_FRAME     = 6'd11;
   localparam logic [5:0]  PAYLOAD_START = 6'd9;
   localparam logic [5:0]  DEST_FIRST    = 6'd2;
   localparam logic [5:0]  DEST_LAST     = 6'd4;
   localparam logic [5:0]  SRC_FIRST     = 6'd5;
   localparam logic [5:0]  SRC_LAST      = 6'd7;
   localparam logic [5:0]  CMD_POS       = 6'd8;
   localparam logic [5:0]  COUNT_MAX     = 6'd63;
   localparam int          PAYLOAD_MAX   = 23;
   localparam int          PAY_IDX_W     = 5;
   localparam logic [15:0] CRC_POLY      = 16'h8408;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_SHORT     = 2'd2;
   localparam logic [1:0] ST_CRC_BAD   = 2'd3;

   typedef logic [PAY_IDX_W-1:0] pay_idx_type;

   typedef struct packed {
      logic        active;
      logic [1:0]  status;
      pay_idx_type idx;
      pay_idx_type cnt;
   } gen_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### hw/rtl/radio_frame_checker_parser.sv
// Radio frame checker and parser: length decode, CRC-16 check, header and
// payload extraction from a byte stream, one result beat per payload byte of a good frame.
// Depends on rfcp_pkg.
//
//   channel  dir  tdata                                        tuser   tlast
//   req_     in   [7:0] rx_byte                                -       capture_end
//   rsp_     out  [23:0] dest_addr [47:24] src_addr            [1:0]   last
//                 [55:48] command [63:56] data_byte                status
//                 [68:64] data_index [73:69] data_count
//
// One input beat per cycle. A byte that completes a frame yields one result
// beat, or one per payload byte (up to 23) for a good frame; the input stalls
// while those drain, and takes the next beat in the cycle the last one moves
// into the output register. The output register lets input continue while a
// result waits on rsp_tready. Synchronous active-high reset clears control
// state; the payload buffer is not reset.
module radio_frame_checker_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rfcp_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [7:0] rx_byte
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rfcp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // dest, src, cmd, data, idx, count
   output logic [rfcp_pkg::RSP_TUSER_W-1:0]     rsp_tuser,  // [1:0] status
   output logic                                 rsp_tlast
);
   import rfcp_pkg::*;

   logic [5:0]  byte_count_ff, byte_count_in;
   logic [5:0]  frame_length_ff, frame_length_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  trailer_low_ff, trailer_low_in;
   logic [23:0] dest_ff, dest_in;
   logic [23:0] src_ff, src_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic        finished_ff, finished_in;
   gen_type     gen_ff, gen_in;
   logic [7:0]  payload_ff [PAYLOAD_MAX];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [23:0] rsp_dest_ff, rsp_src_ff;
   logic [7:0]  rsp_cmd_ff, rsp_data_ff;
   pay_idx_type rsp_idx_ff, rsp_cnt_ff;
   logic        rsp_last_ff;

   logic        accept, rsp_free, gen_move, gen_last, gen_ok, gen_has_data;
   logic [7:0]  rx;
   logic [5:0]  fl, crc_end;
   logic        pay_we;
   pay_idx_type pay_wa;

   assign rx       = req_tdata[7:0];
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign gen_last = (gen_ff.cnt == '0) || ((gen_ff.idx + 1'b1) == gen_ff.cnt);
   assign gen_move = gen_ff.active && rsp_free;
   assign gen_ok   = (gen_ff.status == ST_OK);
   assign gen_has_data = gen_ok && (gen_ff.cnt != '0);
   assign req_tready = !gen_ff.active || (gen_last && rsp_free);
   assign accept   = req_tvalid && req_tready;

   assign fl      = (byte_count_ff == '0) ?
                    (HEADER_BYTES + TRAILER_BYTES + 6'(rx & LEN_MASK)) : frame_length_ff;
   assign crc_end = fl - TRAILER_BYTES;
   assign pay_wa  = PAY_IDX_W'(byte_count_ff - PAYLOAD_START);

   always_comb begin
      byte_count_in   = byte_count_ff;
      frame_length_in = frame_length_ff;
      crc_in          = crc_ff;
      trailer_low_in  = trailer_low_ff;
      dest_in         = dest_ff;
      src_in          = src_ff;
      cmd_in          = cmd_ff;
      finished_in     = finished_ff;
      pay_we          = 1'b0;
      gen_in          = gen_ff;

      if (gen_move) begin
         if (gen_last) begin
            gen_in.active = 1'b0;
         end else begin
            gen_in.idx = gen_ff.idx + 1'b1;
         end
      end

      if (accept) begin
         if (!finished_ff) begin
            frame_length_in = fl;
            if (byte_count_ff < crc_end) begin
               crc_in = crc16_update(crc_ff, rx);
               if (byte_count_ff >= DEST_FIRST && byte_count_ff <= DEST_LAST) begin
                  dest_in = {dest_ff[15:0], rx};
               end else if (byte_count_ff >= SRC_FIRST && byte_count_ff <= SRC_LAST) begin
                  src_in = {src_ff[15:0], rx};
               end else if (byte_count_ff == CMD_POS) begin
                  cmd_in = rx;
               end else if (byte_count_ff >= PAYLOAD_START) begin
                  pay_we = 1'b1;
               end
            end else if (byte_count_ff == crc_end) begin
               trailer_low_in = rx;
            end else begin
               finished_in   = 1'b1;
               gen_in.active = 1'b1;
               gen_in.idx    = '0;
               gen_in.cnt    = '0;
               priority if (fl < MIN_FRAME) begin
                  gen_in.status = ST_SHORT;
               end else if ({rx, trailer_low_ff} != crc_ff) begin
                  gen_in.status = ST_CRC_BAD;
               end else begin
                  gen_in.status = ST_OK;
                  gen_in.cnt    = PAY_IDX_W'(fl - MIN_FRAME);
               end
            end
            if (byte_count_ff != COUNT_MAX) begin
               byte_count_in = byte_count_ff + 1'b1;
            end
         end
         if (req_tlast) begin
            if (!finished_in) begin
               gen_in.active = 1'b1;
               gen_in.status = ST_TRUNCATED;
               gen_in.idx    = '0;
               gen_in.cnt    = '0;
            end
            byte_count_in   = '0;
            frame_length_in = '0;
            crc_in          = '0;
            finished_in     = 1'b0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (gen_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         frame_length_ff <= '0;
         crc_ff          <= '0;
         trailer_low_ff  <= '0;
         dest_ff         <= '0;
         src_ff          <= '0;
         cmd_ff          <= '0;
         finished_ff     <= 1'b0;
         gen_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         byte_count_ff   <= byte_count_in;
         frame_length_ff <= frame_length_in;
         crc_ff          <= crc_in;
         trailer_low_ff  <= trailer_low_in;
         dest_ff         <= dest_in;
         src_ff          <= src_in;
         cmd_ff          <= cmd_in;
         finished_ff     <= finished_in;
         gen_ff          <= gen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         payload_ff[pay_wa] <= rx;
      end
   end

   always_ff @(posedge clock) begin
      if (gen_move) begin
         rsp_status_ff <= gen_ff.status;
         rsp_dest_ff   <= gen_ok ? dest_ff : '0;
         rsp_src_ff    <= gen_ok ? src_ff : '0;
         rsp_cmd_ff    <= gen_ok ? cmd_ff : '0;
         rsp_data_ff   <= gen_has_data ? payload_ff[gen_ff.idx] : '0;
         rsp_idx_ff    <= gen_has_data ? gen_ff.idx : '0;
         rsp_cnt_ff    <= gen_ok ? gen_ff.cnt : '0;
         rsp_last_ff   <= gen_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_cnt_ff, rsp_idx_ff, rsp_data_ff, rsp_cmd_ff,
                        rsp_src_ff, rsp_dest_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hw/rtl/rfcp_checker.sv
// Port-level checks for the radio frame checker and parser, bound to the
// top level. Depends on rfcp_pkg and radio_frame_checker_parser.
module rfcp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rfcp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [rfcp_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input logic                             rsp_tlast
);
   import rfcp_pkg::*;

   logic [4:0] idx, cnt;

   assign idx = rsp_tdata[68:64];
   assign cnt = rsp_tdata[73:69];

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0 && rsp_tlast)
      else $error("error status beat carries data or is not last");

   a_payload_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == ST_OK && !rsp_tlast
      |=> rsp_tvalid && rsp_tuser == ST_OK && idx == $past(idx) + 5'd1
         && cnt == $past(cnt))
      else $error("payload beats out of sequence");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_OK && cnt != '0 |-> (rsp_tlast == (idx + 5'd1 == cnt)))
      else $error("last flag does not match payload position");

endmodule

bind radio_frame_checker_parser rfcp_checker u_rfcp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### tb/radio_frame_checker_parser_check.sv
`timescale 1ns / 100ps
// Checker for the radio frame checker and parser: watches both streams, parses the byte
// stream on its own and compares each result beat field by field. Depends on rfcp_pkg.
module radio_frame_checker_parser_check
   import rfcp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                   rsp_tlast,
   output int                     mismatches,
   output int                     awaiting,
   output int                     results_seen
);

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] dest;
      logic [23:0] src;
      logic [7:0]  cmd;
      logic [7:0]  dbyte;
      logic [4:0]  didx;
      logic [4:0]  dcount;
      logic        last;
   } frame_beat_type;

   frame_beat_type pending_beats[$];
   frame_beat_type oldest;

   logic [5:0]  byte_pos;
   logic [5:0]  length_acc;
   logic [15:0] crc_acc;
   logic [7:0]  trailer_lo;
   logic [23:0] dest_acc;
   logic [23:0] src_acc;
   logic [7:0]  cmd_acc;
   logic [7:0]  payload [PAYLOAD_MAX];
   logic        judged;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 60) begin
         $display("%0t ns: result beat %0d: %s", $time, results_seen, msg);
      end
   endtask

   task automatic queue_beat(input logic [1:0] st, input logic [7:0] db, input logic [4:0] di,
                             input logic [4:0] dc, input logic lst);
      frame_beat_type r;
      r.status = st;
      r.dest   = (st == ST_OK) ? dest_acc : 24'd0;
      r.src    = (st == ST_OK) ? src_acc : 24'd0;
      r.cmd    = (st == ST_OK) ? cmd_acc : 8'd0;
      r.dbyte  = db;
      r.didx   = di;
      r.dcount = dc;
      r.last   = lst;
      pending_beats = {pending_beats, r};
   endtask

   task automatic parse_frame_byte(input logic [7:0] b, input logic cap_end);
      logic [5:0] body;
      logic [5:0] pay_len;
      if (!judged) begin
         if (byte_pos == 6'd0) begin
            length_acc = {1'b0, b[4:0]} + HEADER_BYTES + TRAILER_BYTES;
         end
         body = length_acc - TRAILER_BYTES;
         if (byte_pos < body) begin
            for (int i = 0; i < 8; i++) begin
               crc_acc = (crc_acc[0] ^ b[i]) ? ((crc_acc >> 1) ^ CRC_POLY) : (crc_acc >> 1);
            end
            if (byte_pos >= DEST_FIRST && byte_pos <= DEST_LAST) begin
               dest_acc = {dest_acc[15:0], b};
            end else if (byte_pos >= SRC_FIRST && byte_pos <= SRC_LAST) begin
               src_acc = {src_acc[15:0], b};
            end else if (byte_pos == CMD_POS) begin
               cmd_acc = b;
            end else if (byte_pos >= PAYLOAD_START && byte_pos - PAYLOAD_START < PAYLOAD_MAX) begin
               payload[byte_pos - PAYLOAD_START] = b;
            end
         end else if (byte_pos == body) begin
            trailer_lo = b;
         end else begin
            judged = 1'b1;
            if (length_acc < MIN_FRAME) begin
               queue_beat(ST_SHORT, 8'd0, 5'd0, 5'd0, 1'b1);
            end else if ({b, trailer_lo} != crc_acc) begin
               queue_beat(ST_CRC_BAD, 8'd0, 5'd0, 5'd0, 1'b1);
            end else begin
               pay_len = length_acc - MIN_FRAME;
               if (pay_len == 6'd0) begin
                  queue_beat(ST_OK, 8'd0, 5'd0, 5'd0, 1'b1);
               end else begin
                  for (int k = 0; k < pay_len; k++) begin
                     queue_beat(ST_OK, payload[k], 5'(k), pay_len[4:0], k == pay_len - 1);
                  end
               end
            end
         end
         if (byte_pos < COUNT_MAX) begin
            byte_pos++;
         end
      end
      if (cap_end) begin
         if (!judged) begin
            queue_beat(ST_TRUNCATED, 8'd0, 5'd0, 5'd0, 1'b1);
         end
         byte_pos   = 6'd0;
         length_acc = 6'd0;
         crc_acc    = 16'd0;
         judged     = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_beats.delete();
         byte_pos     = 6'd0;
         length_acc   = 6'd0;
         crc_acc      = 16'd0;
         trailer_lo   = 8'd0;
         dest_acc     = 24'd0;
         src_acc      = 24'd0;
         cmd_acc      = 8'd0;
         judged       = 1'b0;
         foreach (payload[i]) payload[i] = 8'd0;
         mismatches   = 0;
         results_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, status %0d", rsp_tuser));
            end else begin
               oldest = pending_beats.pop_front();
               if (rsp_tuser != oldest.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tuser, oldest.status));
               if (rsp_tdata[23:0] != oldest.dest)
                  report_mismatch($sformatf("destination %h, expected %h",
                                            rsp_tdata[23:0], oldest.dest));
               if (rsp_tdata[47:24] != oldest.src)
                  report_mismatch($sformatf("source %h, expected %h",
                                            rsp_tdata[47:24], oldest.src));
               if (rsp_tdata[55:48] != oldest.cmd)
                  report_mismatch($sformatf("command %h, expected %h",
                                            rsp_tdata[55:48], oldest.cmd));
               if (rsp_tdata[63:56] != oldest.dbyte)
                  report_mismatch($sformatf("data_byte %h, expected %h",
                                            rsp_tdata[63:56], oldest.dbyte));
               if (rsp_tdata[68:64] != oldest.didx)
                  report_mismatch($sformatf("data_index %0d, expected %0d",
                                            rsp_tdata[68:64], oldest.didx));
               if (rsp_tdata[73:69] != oldest.dcount)
                  report_mismatch($sformatf("data_count %0d, expected %0d",
                                            rsp_tdata[73:69], oldest.dcount));
               if (rsp_tlast != oldest.last)
                  report_mismatch($sformatf("last %b, expected %b", rsp_tlast, oldest.last));
               if (rsp_tdata[79:74] != 6'd0)
                  report_mismatch($sformatf("pad bits %b, expected zero", rsp_tdata[79:74]));
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            parse_frame_byte(req_tdata, req_tlast);
         end
      end
      awaiting = pending_beats.size();
   end

endmodule

### tb/radio_frame_checker_parser_test.sv
`timescale 1ns / 100ps
// Top of the radio frame checker and parser testbench: clock, reset, capture stimulus
// with idling phases and an output hold, and the verdict. Depends on rfcp_pkg, the block
// and radio_frame_checker_parser_check.
module radio_frame_checker_parser_test;
   import rfcp_pkg::*;

   localparam int RANDOM_BEATS = 96;
   localparam int PHASE_BEATS  = RANDOM_BEATS / 4;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   int   mismatches;
   int   awaiting;
   int   results_seen;
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic hold_request  = 1'b0;
   logic holding       = 1'b0;
   int   beats_sent    = 0;
   int   intact_caps   = 0;
   int   corrupt_caps  = 0;
   int   cut_caps      = 0;
   int   noise_caps    = 0;

   logic [7:0] capture_buf[$];

   radio_frame_checker_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   radio_frame_checker_parser_check check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .mismatches   (mismatches),
      .awaiting     (awaiting),
      .results_seen (results_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= !holding && ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      wait (hold_request);
      @(posedge clock);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [15:0] kermit_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic lst);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_capture;
      foreach (capture_buf[i]) send_beat(capture_buf[i], i == capture_buf.size() - 1);
   endtask

   // fill < 0: random body bytes, else every body byte after byte 0 is fill
   task automatic build_frame(input logic [7:0] head, input int fill);
      int          len;
      logic [15:0] crc;
      len = 3 + head[4:0];
      crc = 16'd0;
      capture_buf.delete();
      capture_buf = {capture_buf, head};
      for (int i = 1; i < len - 2; i++) begin
         capture_buf = {capture_buf, (fill < 0) ? 8'($urandom) : 8'(fill)};
      end
      foreach (capture_buf[i]) crc = kermit_step(crc, capture_buf[i]);
      capture_buf = {capture_buf, crc[7:0]};
      capture_buf = {capture_buf, crc[15:8]};
   endtask

   task automatic flip_one_bit;
      int pos;
      pos = $urandom_range(1, capture_buf.size() - 1);
      capture_buf[pos] = capture_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
   endtask

   task automatic random_capture(input bit force_max);
      logic [7:0] head;
      int         pick;
      int         keep;
      head = 8'($urandom);
      if (force_max) begin
         head[4:0] = 5'd31;
      end else if ($urandom_range(0, 9) < 8) begin
         head[4:0] = 5'($urandom_range(6, 14));
      end
      pick = force_max ? 0 : $urandom_range(0, 99);
      build_frame(head, -1);
      if (pick < 70) begin
         intact_caps++;
      end else if (pick < 82) begin
         flip_one_bit();
         corrupt_caps++;
      end else if (pick < 92) begin
         keep = $urandom_range(1, capture_buf.size() - 1);
         while (capture_buf.size() > keep) void'(capture_buf.pop_back());
         cut_caps++;
      end else begin
         capture_buf.delete();
         repeat ($urandom_range(1, 6)) capture_buf = {capture_buf, 8'($urandom)};
         noise_caps++;
      end
      if (pick < 82 && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) capture_buf = {capture_buf, 8'($urandom)};
      end
      send_capture();
   endtask

   initial begin
      int phase_start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // one-byte capture: truncated
      capture_buf = '{8'hFF};
      send_capture();
      // three-byte frame is short; trailing byte is ignored
      capture_buf = '{8'h00, 8'h00, 8'h00, 8'hFF};
      send_capture();
      // capture ends before the three-byte frame does
      capture_buf = '{8'hE0, 8'h5A};
      send_capture();
      // smallest good frame, address and command bytes all ones, empty payload
      build_frame(8'hE8, 8'hFF);
      send_capture();
      // smallest frame with a damaged trailer
      build_frame(8'h08, 8'h00);
      capture_buf[10] = capture_buf[10] ^ 8'h80;
      send_capture();
      intact_caps  += 2;
      corrupt_caps += 1;
      cut_caps     += 2;

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         if (ph == 0) hold_request = 1'b1;
         phase_start = beats_sent;
         random_capture(ph == 0 || ph == 2);
         while (beats_sent - phase_start < PHASE_BEATS) random_capture(1'b0);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d byte beats in %0d captures: %0d intact, %0d corrupted, %0d cut,",
               beats_sent, intact_caps + corrupt_caps + cut_caps + noise_caps, intact_caps,
               corrupt_caps, cut_caps);
      $display("%0d noise; checked %0d result beats across four idling phases and a %0d-cycle hold",
               noise_caps, results_seen, HOLD_CYCLES);
      if (mismatches == 0 && awaiting == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
